// ===== src/rbas_pkg.sv =====
// Shared types and constants for the repeating beep alert sequencer.
package rbas_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_PREROLL = 3'd1,
		PH_BEEP    = 3'd2,
		PH_GAP     = 3'd3,
		PH_TRAIL   = 3'd4,
		PH_WAIT    = 3'd5
	} phase_t;

	localparam logic [1:0] FN_TICK      = 2'd0;
	localparam logic [1:0] FN_SET_ERROR = 2'd1;
	localparam logic [1:0] FN_ACK       = 2'd2;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FAULT_KEY_W = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_PREROLL    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BEEP       = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_GAP        = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_TRAIL      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_REPEAT     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_BEEP_TOTAL = 3'd5;

	typedef struct packed {
		logic [9:0]  preroll_ticks;
		logic [9:0]  beep_ticks;
		logic [9:0]  gap_ticks;
		logic [9:0]  trailing_ticks;
		logic [15:0] repeat_ticks;
		logic [3:0]  beep_total;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		preroll_ticks:  10'd10,
		beep_ticks:     10'd15,
		gap_ticks:      10'd10,
		trailing_ticks: 10'd20,
		repeat_ticks:   16'd300,
		beep_total:     4'd3
	};

endpackage

// ===== src/rbas_if.sv =====
// Channel interfaces for events, results and configuration writes.
interface rbas_evt_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         func;
	logic                               error_on;
	logic [rbas_pkg::FAULT_KEY_W-1:0]   fault_key;
	logic                               amp_ready;

	modport source(output valid, func, error_on, fault_key, amp_ready, input ready);
	modport sink(input valid, func, error_on, fault_key, amp_ready, output ready);
endinterface

interface rbas_rsp_if;
	logic       valid;
	logic       ready;
	logic       amp_enable;
	logic       tone_on;
	logic [2:0] pattern_phase;
	logic [3:0] beep_number;
	logic       alert_pending;

	modport source(output valid, amp_enable, tone_on, pattern_phase, beep_number,
		alert_pending, input ready);
	modport sink(input valid, amp_enable, tone_on, pattern_phase, beep_number,
		alert_pending, output ready);
endinterface

interface rbas_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rbas_pkg::CFG_ADDR_W-1:0]   addr;
	logic [rbas_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ===== src/repeating_beep_alert_sequencer.sv =====
// Top level of the repeating beep alert sequencer.
// Each event item (a 10 ms tick, a set-error or an acknowledge) is captured in an input
// register and handled in one pass of logic once the result register can take it; that
// pass updates the alert latch and the pattern counters and loads the result register;
// one result item comes out per event, and a new event is taken every cycle as long as
// results are taken. The alert state and the pattern position advance once per item, so
// that single pass sets the rate. The user must write configuration through the register
// port only while no event is in flight; the block itself does not enforce this.
module repeating_beep_alert_sequencer #(
	parameter int KEY_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	rbas_evt_if.sink   evt,
	rbas_rsp_if.source rsp,
	rbas_cfg_if.sink   cfg
);

	typedef struct packed {
		rbas_pkg::phase_t ph;
		logic [3:0]       bc;
	} pos_t;

	rbas_pkg::cfg_t regs;

	rbas_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	function automatic pos_t skip_empty(pos_t p, rbas_pkg::cfg_t c);
		pos_t r;
		r = p;
		if (r.ph == rbas_pkg::PH_PREROLL && c.preroll_ticks == 10'd0) begin
			r.bc = 4'd0;
			r.ph = (c.beep_total == 4'd0) ? rbas_pkg::PH_TRAIL : rbas_pkg::PH_BEEP;
		end
		if (r.ph == rbas_pkg::PH_BEEP && c.beep_ticks == 10'd0) begin
			r.ph = (({1'b0, r.bc} + 5'd1) < {1'b0, c.beep_total}) ?
				rbas_pkg::PH_GAP : rbas_pkg::PH_TRAIL;
		end
		if (r.ph == rbas_pkg::PH_GAP && c.gap_ticks == 10'd0) begin
			r.bc = r.bc + 4'd1;
			r.ph = rbas_pkg::PH_BEEP;
		end
		// With empty beeps and empty gaps the rest of the beeps collapse into the trailer.
		if (r.ph == rbas_pkg::PH_BEEP && c.beep_ticks == 10'd0) begin
			r.ph = rbas_pkg::PH_TRAIL;
		end
		if (r.ph == rbas_pkg::PH_TRAIL && c.trailing_ticks == 10'd0) begin
			r.ph = rbas_pkg::PH_WAIT;
		end
		return r;
	endfunction

	function automatic pos_t advance(pos_t p, rbas_pkg::cfg_t c);
		pos_t r;
		r = p;
		case (p.ph)
			rbas_pkg::PH_PREROLL: begin
				r.bc = 4'd0;
				r.ph = (c.beep_total == 4'd0) ? rbas_pkg::PH_TRAIL : rbas_pkg::PH_BEEP;
			end
			rbas_pkg::PH_BEEP: begin
				r.ph = (({1'b0, p.bc} + 5'd1) < {1'b0, c.beep_total}) ?
					rbas_pkg::PH_GAP : rbas_pkg::PH_TRAIL;
			end
			rbas_pkg::PH_GAP: begin
				r.bc = p.bc + 4'd1;
				r.ph = rbas_pkg::PH_BEEP;
			end
			rbas_pkg::PH_TRAIL: r.ph = rbas_pkg::PH_WAIT;
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [9:0] seg_len(rbas_pkg::phase_t ph, rbas_pkg::cfg_t c);
		logic [9:0] len;
		case (ph)
			rbas_pkg::PH_PREROLL: len = c.preroll_ticks;
			rbas_pkg::PH_BEEP:    len = c.beep_ticks;
			rbas_pkg::PH_GAP:     len = c.gap_ticks;
			rbas_pkg::PH_TRAIL:   len = c.trailing_ticks;
			default:              len = 10'd1;
		endcase
		return len;
	endfunction

	// Input register.
	logic                 valid_s1;
	logic [1:0]           func_s1;
	logic                 error_on_s1;
	logic [KEY_WIDTH-1:0] key_s1;
	logic                 amp_ready_s1;

	// Alert latch and pattern state.
	logic                 alert_active_q, alert_acked_q;
	logic [KEY_WIDTH-1:0] latched_key_q, cycle_key_q;
	rbas_pkg::phase_t     phase_q;
	logic [9:0]           seg_q;
	logic [3:0]           bc_q;
	logic [15:0]          elapsed_q;

	// Result register.
	logic       rsp_valid_q;
	logic       amp_enable_q, tone_on_q, alert_pending_q;
	logic [2:0] pattern_phase_q;
	logic [3:0] beep_number_q;

	logic                 fire;
	logic                 n_active, n_acked;
	logic [KEY_WIDTH-1:0] n_latched, n_cycle;
	pos_t                 pos, rep;
	logic [9:0]           n_seg;
	logic [15:0]          n_elapsed;
	logic                 pend;
	logic                 r_amp, r_tone;
	logic [3:0]           r_bn;

	assign fire      = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign evt.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			func_s1      <= evt.func;
			error_on_s1  <= evt.error_on;
			key_s1       <= KEY_WIDTH'(evt.fault_key);
			amp_ready_s1 <= evt.amp_ready;
		end
	end

	// Next state of the alert latch and the pattern sequencer.
	always_comb begin
		n_active  = alert_active_q;
		n_acked   = alert_acked_q;
		n_latched = latched_key_q;
		n_cycle   = cycle_key_q;
		pos       = '{ph: phase_q, bc: bc_q};
		n_seg     = seg_q;
		n_elapsed = elapsed_q;
		pend      = alert_active_q && !alert_acked_q;
		rep       = pos;
		unique case (func_s1)
			rbas_pkg::FN_TICK: begin
				if (pos.ph != rbas_pkg::PH_IDLE && !(pend && latched_key_q == cycle_key_q)) begin
					pos   = '{ph: rbas_pkg::PH_IDLE, bc: 4'd0};
					n_seg = 10'd0;
				end
				if (pos.ph == rbas_pkg::PH_WAIT && elapsed_q >= regs.repeat_ticks) begin
					pos   = '{ph: rbas_pkg::PH_IDLE, bc: 4'd0};
					n_seg = 10'd0;
				end
				if (pos.ph == rbas_pkg::PH_IDLE && pend) begin
					if (!amp_ready_s1) begin
						n_acked = 1'b1;
					end else begin
						n_cycle   = latched_key_q;
						n_elapsed = 16'd0;
						n_seg     = 10'd0;
						pos       = skip_empty('{ph: rbas_pkg::PH_PREROLL, bc: 4'd0}, regs);
					end
				end
				rep = pos;
				if (pos.ph != rbas_pkg::PH_IDLE) begin
					if (n_elapsed != 16'hFFFF) begin
						n_elapsed = n_elapsed + 16'd1;
					end
					if (pos.ph != rbas_pkg::PH_WAIT) begin
						n_seg = n_seg + 10'd1;
						if (n_seg >= seg_len(pos.ph, regs)) begin
							n_seg = 10'd0;
							pos   = skip_empty(advance(pos, regs), regs);
						end
					end
				end
			end
			rbas_pkg::FN_SET_ERROR: begin
				if (!error_on_s1) begin
					n_active  = 1'b0;
					n_acked   = 1'b0;
					n_latched = '0;
				end else begin
					if (!alert_active_q || latched_key_q != key_s1) begin
						n_acked = 1'b0;
					end
					n_active  = 1'b1;
					n_latched = key_s1;
				end
			end
			rbas_pkg::FN_ACK: begin
				if (alert_active_q) begin
					n_acked = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields for the reported chunk.
	always_comb begin
		r_amp  = 1'b0;
		r_tone = 1'b0;
		r_bn   = 4'd0;
		case (rep.ph) inside
			rbas_pkg::PH_PREROLL, rbas_pkg::PH_TRAIL: r_amp = 1'b1;
			rbas_pkg::PH_BEEP: begin
				r_amp  = 1'b1;
				r_tone = (func_s1 == rbas_pkg::FN_TICK);
				r_bn   = rep.bc;
			end
			rbas_pkg::PH_GAP: begin
				r_amp = 1'b1;
				r_bn  = rep.bc;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_active_q <= 1'b0;
			alert_acked_q  <= 1'b0;
			latched_key_q  <= '0;
			cycle_key_q    <= '0;
			phase_q        <= rbas_pkg::PH_IDLE;
			seg_q          <= 10'd0;
			bc_q           <= 4'd0;
			elapsed_q      <= 16'd0;
		end else if (fire) begin
			alert_active_q <= n_active;
			alert_acked_q  <= n_acked;
			latched_key_q  <= n_latched;
			cycle_key_q    <= n_cycle;
			phase_q        <= pos.ph;
			seg_q          <= n_seg;
			bc_q           <= pos.bc;
			elapsed_q      <= n_elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			amp_enable_q    <= r_amp;
			tone_on_q       <= r_tone;
			pattern_phase_q <= rep.ph;
			beep_number_q   <= r_bn;
			alert_pending_q <= n_active && !n_acked;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.amp_enable    = amp_enable_q;
	assign rsp.tone_on       = tone_on_q;
	assign rsp.pattern_phase = pattern_phase_q;
	assign rsp.beep_number   = beep_number_q;
	assign rsp.alert_pending = alert_pending_q;

endmodule

// ===== src/rbas_cfg_regs.sv =====
// Configuration register file of the beep alert sequencer.
module rbas_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	rbas_cfg_if.sink      cfg,
	output rbas_pkg::cfg_t regs
);

	rbas_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= rbas_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				rbas_pkg::REG_PREROLL:    regs_q.preroll_ticks  <= cfg.data[9:0];
				rbas_pkg::REG_BEEP:       regs_q.beep_ticks     <= cfg.data[9:0];
				rbas_pkg::REG_GAP:        regs_q.gap_ticks      <= cfg.data[9:0];
				rbas_pkg::REG_TRAIL:      regs_q.trailing_ticks <= cfg.data[9:0];
				rbas_pkg::REG_REPEAT:     regs_q.repeat_ticks   <= cfg.data[15:0];
				rbas_pkg::REG_BEEP_TOTAL: regs_q.beep_total     <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sim/repeating_beep_alert_sequencer_tb.sv =====
// Self-checking testbench: directed and random events against a model of the beep alert pattern.
module repeating_beep_alert_sequencer_tb;

	typedef struct packed {
		logic       amp_enable;
		logic       tone_on;
		logic [2:0] pattern_phase;
		logic [3:0] beep_number;
		logic       alert_pending;
	} beep_result_t;

	typedef struct packed {
		logic [1:0]                       func;
		logic                             error_on;
		logic [rbas_pkg::FAULT_KEY_W-1:0] fault_key;
		logic                             amp_ready;
		logic                             typed;
		beep_result_t                     want;
	} event_row_t;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam logic [rbas_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
	localparam logic TYPED = 1'b1;
	localparam logic PREDICTED = 1'b0;
	localparam int QUIET_LIMIT = 2000;
	localparam int ROUNDS = 8;
	localparam int ROUND_ITEMS = 215;

	localparam beep_result_t SILENT_IDLE = '{1'b0, 1'b0, rbas_pkg::PH_IDLE, 4'd0, 1'b0};
	localparam beep_result_t ARMED_IDLE = '{1'b0, 1'b0, rbas_pkg::PH_IDLE, 4'd0, 1'b1};
	localparam beep_result_t FIRST_PREROLL = '{1'b1, 1'b0, rbas_pkg::PH_PREROLL, 4'd0, 1'b1};
	localparam beep_result_t NOT_TYPED = '0;

	logic clk = 1'b0;
	logic arst_n;

	rbas_evt_if evt_ch ();
	rbas_rsp_if rsp_ch ();
	rbas_cfg_if cfg_ch ();

	repeating_beep_alert_sequencer #(.KEY_WIDTH(rbas_pkg::FAULT_KEY_W)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rbas_pkg::cfg_t                   cfg_m;
	logic                             alert_active;
	logic                             alert_acked;
	logic [rbas_pkg::FAULT_KEY_W-1:0] latched_key;
	logic [rbas_pkg::FAULT_KEY_W-1:0] cycle_key;
	rbas_pkg::phase_t                 phase_m;
	logic [9:0]                       seg_cnt;
	logic [3:0]                       beep_cnt;
	logic [15:0]                      elapsed_m;

	beep_result_t                     expected_chunks[$];
	beep_result_t                     want_r;
	event_row_t                       directed_events[25];
	logic [rbas_pkg::FAULT_KEY_W-1:0] key_pool[2];
	int                               mismatches = 0;
	int                               quiet_cycles = 0;
	int unsigned                      send_idle_pct = 0;
	int unsigned                      stall_pct = 0;

	function automatic logic is_pending();
		return alert_active && !alert_acked;
	endfunction

	function automatic logic [9:0] segment_length(rbas_pkg::phase_t p);
		case (p)
			rbas_pkg::PH_PREROLL: return cfg_m.preroll_ticks;
			rbas_pkg::PH_BEEP:    return cfg_m.beep_ticks;
			rbas_pkg::PH_GAP:     return cfg_m.gap_ticks;
			rbas_pkg::PH_TRAIL:   return cfg_m.trailing_ticks;
			default:              return 10'd1;
		endcase
	endfunction

	function automatic logic [3:0] current_beep();
		return (phase_m == rbas_pkg::PH_BEEP || phase_m == rbas_pkg::PH_GAP) ? beep_cnt : 4'd0;
	endfunction

	function automatic void go_idle();
		phase_m = rbas_pkg::PH_IDLE;
		seg_cnt = '0;
		beep_cnt = '0;
	endfunction

	function automatic void bump_elapsed();
		if (elapsed_m != 16'hFFFF)
			elapsed_m = elapsed_m + 16'd1;
	endfunction

	function automatic void next_segment();
		seg_cnt = '0;
		case (phase_m)
			rbas_pkg::PH_PREROLL: begin
				beep_cnt = '0;
				if (cfg_m.beep_total == 4'd0)
					phase_m = rbas_pkg::PH_TRAIL;
				else
					phase_m = rbas_pkg::PH_BEEP;
			end
			rbas_pkg::PH_BEEP: begin
				if (beep_cnt + 1 < cfg_m.beep_total)
					phase_m = rbas_pkg::PH_GAP;
				else
					phase_m = rbas_pkg::PH_TRAIL;
			end
			rbas_pkg::PH_GAP: begin
				beep_cnt = beep_cnt + 4'd1;
				phase_m = rbas_pkg::PH_BEEP;
			end
			rbas_pkg::PH_TRAIL: phase_m = rbas_pkg::PH_WAIT;
			default: ;
		endcase
	endfunction

	function automatic void skip_empty_segments();
		while (phase_m >= rbas_pkg::PH_PREROLL && phase_m <= rbas_pkg::PH_TRAIL &&
				segment_length(phase_m) == 10'd0)
			next_segment();
	endfunction

	function automatic beep_result_t advance_alert(logic [1:0] f, logic on,
			logic [rbas_pkg::FAULT_KEY_W-1:0] key, logic rdy);
		beep_result_t r;
		r = '0;
		if (f == rbas_pkg::FN_TICK) begin
			if (phase_m != rbas_pkg::PH_IDLE && !(is_pending() && latched_key == cycle_key))
				go_idle();
			if (phase_m == rbas_pkg::PH_WAIT && elapsed_m >= cfg_m.repeat_ticks)
				go_idle();
			if (phase_m == rbas_pkg::PH_IDLE && is_pending()) begin
				if (!rdy) begin
					alert_acked = 1'b1;
				end else begin
					cycle_key = latched_key;
					elapsed_m = '0;
					phase_m = rbas_pkg::PH_PREROLL;
					seg_cnt = '0;
					beep_cnt = '0;
					skip_empty_segments();
				end
			end
			if (phase_m == rbas_pkg::PH_WAIT) begin
				r.pattern_phase = rbas_pkg::PH_WAIT;
				bump_elapsed();
			end else if (phase_m != rbas_pkg::PH_IDLE) begin
				r.pattern_phase = phase_m;
				r.amp_enable = 1'b1;
				r.tone_on = (phase_m == rbas_pkg::PH_BEEP);
				r.beep_number = current_beep();
				bump_elapsed();
				seg_cnt = seg_cnt + 10'd1;
				if (seg_cnt >= segment_length(phase_m)) begin
					next_segment();
					skip_empty_segments();
				end
			end
		end else begin
			if (f == rbas_pkg::FN_SET_ERROR) begin
				if (!on) begin
					alert_active = 1'b0;
					alert_acked = 1'b0;
					latched_key = '0;
				end else begin
					if (!alert_active || latched_key != key)
						alert_acked = 1'b0;
					alert_active = 1'b1;
					latched_key = key;
				end
			end else if (f == rbas_pkg::FN_ACK) begin
				if (alert_active)
					alert_acked = 1'b1;
			end
			r.pattern_phase = phase_m;
			r.amp_enable = (phase_m >= rbas_pkg::PH_PREROLL && phase_m <= rbas_pkg::PH_TRAIL);
			r.beep_number = current_beep();
		end
		r.alert_pending = is_pending();
		return r;
	endfunction

	task automatic send_event(input logic [1:0] f, input logic on,
			input logic [rbas_pkg::FAULT_KEY_W-1:0] key, input logic rdy,
			input logic typed, input beep_result_t want);
		beep_result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			evt_ch.valid = 1'b0;
			@(negedge clk);
		end
		evt_ch.valid = 1'b1;
		evt_ch.func = f;
		evt_ch.error_on = on;
		evt_ch.fault_key = key;
		evt_ch.amp_ready = rdy;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
		predicted = advance_alert(f, on, key, rdy);
		expected_chunks.push_back(typed ? want : predicted);
	endtask

	task automatic write_reg(input logic [rbas_pkg::CFG_ADDR_W-1:0] idx,
			input logic [15:0] value);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.addr = idx;
		cfg_ch.data = value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			rbas_pkg::REG_PREROLL:    cfg_m.preroll_ticks = value[9:0];
			rbas_pkg::REG_BEEP:       cfg_m.beep_ticks = value[9:0];
			rbas_pkg::REG_GAP:        cfg_m.gap_ticks = value[9:0];
			rbas_pkg::REG_TRAIL:      cfg_m.trailing_ticks = value[9:0];
			rbas_pkg::REG_REPEAT:     cfg_m.repeat_ticks = value;
			rbas_pkg::REG_BEEP_TOTAL: cfg_m.beep_total = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Upper data bits beyond each register's width are randomized and must be dropped.
	task automatic program_pattern(input int unsigned pre, input int unsigned beep,
			input int unsigned gap, input int unsigned trail, input int unsigned rep,
			input int unsigned total);
		write_reg(rbas_pkg::REG_PREROLL, 16'(($urandom() & 32'hFC00) | pre));
		write_reg(rbas_pkg::REG_BEEP, 16'(($urandom() & 32'hFC00) | beep));
		write_reg(rbas_pkg::REG_GAP, 16'(($urandom() & 32'hFC00) | gap));
		write_reg(rbas_pkg::REG_TRAIL, 16'(($urandom() & 32'hFC00) | trail));
		write_reg(rbas_pkg::REG_REPEAT, 16'(rep));
		write_reg(rbas_pkg::REG_BEEP_TOTAL, 16'(($urandom() & 32'hFFF0) | total));
		write_reg(REG_UNUSED, 16'($urandom()));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		evt_ch.valid = 1'b0;
		while (expected_chunks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_chunks.size() == 0) begin
				$display("%0t: result with nothing expected, got %b %b %0d %0d %b", $time,
					rsp_ch.amp_enable, rsp_ch.tone_on, rsp_ch.pattern_phase,
					rsp_ch.beep_number, rsp_ch.alert_pending);
				mismatches++;
			end else begin
				want_r = expected_chunks.pop_front();
				check_field("amp_enable", 32'(want_r.amp_enable), 32'(rsp_ch.amp_enable));
				check_field("tone_on", 32'(want_r.tone_on), 32'(rsp_ch.tone_on));
				check_field("pattern_phase", 32'(want_r.pattern_phase),
					32'(rsp_ch.pattern_phase));
				check_field("beep_number", 32'(want_r.beep_number), 32'(rsp_ch.beep_number));
				check_field("alert_pending", 32'(want_r.alert_pending),
					32'(rsp_ch.alert_pending));
			end
		end
	end

	always @(posedge clk) begin
		if ((evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.func = rbas_pkg::FN_TICK;
		evt_ch.error_on = 1'b0;
		evt_ch.fault_key = '0;
		evt_ch.amp_ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = rbas_pkg::REG_PREROLL;
		cfg_ch.data = '0;

		cfg_m = rbas_pkg::CFG_RESET;
		alert_active = 1'b0;
		alert_acked = 1'b0;
		latched_key = '0;
		cycle_key = '0;
		go_idle();
		elapsed_m = '0;

		directed_events = '{
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, TYPED, SILENT_IDLE},
			'{rbas_pkg::FN_ACK, 1'b0, 32'h0000_0000, 1'b1, TYPED, SILENT_IDLE},
			'{FN_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b1, TYPED, SILENT_IDLE},
			'{rbas_pkg::FN_SET_ERROR, 1'b1, 32'hFFFF_FFFF, 1'b0, TYPED, ARMED_IDLE},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, TYPED, FIRST_PREROLL},
			'{rbas_pkg::FN_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_SET_ERROR, 1'b1, 32'hFFFF_FFFF, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_SET_ERROR, 1'b1, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_ACK, 1'b1, 32'hFFFF_FFFF, 1'b0, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_SET_ERROR, 1'b1, 32'hA5A5_A5A5, 1'b1, TYPED, ARMED_IDLE},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b0, TYPED, SILENT_IDLE},
			'{rbas_pkg::FN_SET_ERROR, 1'b1, 32'hA5A5_A5A5, 1'b0, TYPED, SILENT_IDLE},
			'{rbas_pkg::FN_SET_ERROR, 1'b0, 32'hFFFF_FFFF, 1'b1, TYPED, SILENT_IDLE},
			'{rbas_pkg::FN_ACK, 1'b0, 32'h0000_0000, 1'b1, TYPED, SILENT_IDLE},
			'{rbas_pkg::FN_SET_ERROR, 1'b1, 32'h5A5A_5A5A, 1'b1, TYPED, ARMED_IDLE},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_TICK, 1'b1, 32'hFFFF_FFFF, 1'b0, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_SET_ERROR, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED},
			'{rbas_pkg::FN_TICK, 1'b0, 32'h0000_0000, 1'b1, PREDICTED, NOT_TYPED}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_events[i])
			send_event(directed_events[i].func, directed_events[i].error_on,
				directed_events[i].fault_key, directed_events[i].amp_ready,
				directed_events[i].typed, directed_events[i].want);
		wait_idle();

		for (int round = 0; round < ROUNDS; round++) begin
			send_idle_pct = 0;
			stall_pct = 0;
			case (round)
				0: program_pattern(0, 0, 0, 0, 0, 0);
				1: program_pattern(1023, 1023, 1023, 1023, 65535, 15);
				2: program_pattern(0, 1, 0, 1, 40, 15);
				default: program_pattern($urandom_range(3), $urandom_range(3),
					$urandom_range(3), $urandom_range(3), $urandom_range(40),
					$urandom_range(5));
			endcase
			case (round % 4)
				1: send_idle_pct = 50;
				2: stall_pct = 50;
				3: begin
					send_idle_pct = 13;
					stall_pct = 13;
				end
				default: ;
			endcase
			key_pool[0] = $urandom();
			key_pool[1] = $urandom();

			// Mostly ticks so that patterns play out; alert changes come in now and then.
			for (int n = 0; n < ROUND_ITEMS; n++) begin
				int unsigned                      pick;
				logic [1:0]                       f;
				logic                             on;
				logic [rbas_pkg::FAULT_KEY_W-1:0] key;
				logic                             rdy;
				pick = $urandom_range(99);
				on = 1'($urandom_range(1));
				key = $urandom();
				rdy = ($urandom_range(9) != 0);
				if (pick < 90) begin
					f = rbas_pkg::FN_TICK;
				end else if (pick < 96) begin
					f = rbas_pkg::FN_SET_ERROR;
					on = ($urandom_range(9) != 0);
					if ($urandom_range(19) > 2)
						key = key_pool[1'($urandom_range(1))];
				end else if (pick < 99) begin
					f = rbas_pkg::FN_ACK;
				end else begin
					f = FN_UNUSED;
				end
				send_event(f, on, key, rdy, PREDICTED, NOT_TYPED);
				if (n == ROUND_ITEMS / 2)
					wait_idle();
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_chunks.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== repeating_beep_alert_sequencer.f =====
src/rbas_pkg.sv
src/rbas_if.sv
src/rbas_cfg_regs.sv
src/repeating_beep_alert_sequencer.sv
sim/repeating_beep_alert_sequencer_tb.sv
